[src/fit_policy_block_allocator_defines.svh]
// Assertion macros for the fit-policy block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

`define FPBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FPBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FPBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define FPBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/fpba_pkg.sv]
// Shared constants of the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

    localparam int OP_W       = 1;
    localparam int SLOT_W     = 3;
    localparam int AMOUNT_W   = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_REQ  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [MODE_W-1:0]  MODE_RST  = MODE_FIRST;
    localparam logic [COUNT_W-1:0] COUNT_RST = 4'd8;

endpackage

`default_nettype wire

[src/fpba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: sequencer, compare unit and size table.
//
// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              i_op, i_slot, i_amount
// result    out        o_done, one-cycle strobe   o_fit_found, o_chosen_slot, o_left_over
// config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load leaves busy low; its result strobes the next cycle.
// A request holds busy high for one table RAM read and one compare per in-use block,
// then a drain step and a write-back step that stores the chosen block's left-over
// size.
// Reset is synchronous: it clears the entry valid bits (table reads as zero) and
// sets fit_mode to first fit and block_count to 8.
// The result cannot be stalled; config is always ready.
`default_nettype none
`include "fit_policy_block_allocator_defines.svh"

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [fpba_pkg::OP_W-1:0]        i_op,
    input  wire logic [fpba_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic [fpba_pkg::AMOUNT_W-1:0]    i_amount,
    output logic                                  o_done,
    output logic                                  o_fit_found,
    output logic      [fpba_pkg::SLOT_W-1:0]      o_chosen_slot,
    output logic      [fpba_pkg::AMOUNT_W-1:0]    o_left_over,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW    = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int SW    = fpba_pkg::SLOT_W;
    localparam int AW    = fpba_pkg::AMOUNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [fpba_pkg::MODE_W-1:0]   r_mode;
    logic [fpba_pkg::COUNT_W-1:0]  r_count;
    logic [NUM_BLOCKS-1:0]         r_vld;
    logic [CNT_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_used;
    logic                          r_rd_vld;
    logic                          r_rd_vbit;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_found;
    logic [IW-1:0]                 r_pick;
    logic [SIZE_BITS-1:0]          r_best;
    logic [AW-1:0]                 r_amount;
    logic                          r_done;
    logic                          r_fit_found;
    logic [SW-1:0]                 r_chosen;
    logic [AW-1:0]                 r_left;

    logic                          accept;
    logic                          load_acc;
    logic                          req_acc;
    logic [IW+SW-1:0]              slot_ext;
    logic                          slot_ok;
    logic [IW-1:0]                 load_addr;
    logic [SIZE_BITS+AW-1:0]       load_ext;
    logic [SIZE_BITS-1:0]          load_size;
    logic [SIZE_BITS+AW-1:0]       load_wide;
    logic [CNT_W-1:0]              used_sat;
    logic                          issue;
    logic [SIZE_BITS-1:0]          ram_rdata;
    logic [SIZE_BITS-1:0]          cur_size;
    logic [SIZE_BITS+AW-1:0]       size_wide;
    logic [SIZE_BITS+AW-1:0]       amt_wide;
    logic [SIZE_BITS-1:0]          amt_trunc;
    logic                          fits;
    logic [SIZE_BITS-1:0]          rem;
    logic                          better;
    logic                          take;
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [SIZE_BITS-1:0]          ram_wdata;
    logic [IW+SW-1:0]              pick_ext;
    logic [SIZE_BITS+AW-1:0]       best_wide;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start & ~busy;
    assign load_acc    = accept & (i_op == fpba_pkg::OP_LOAD);
    assign req_acc     = accept & (i_op == fpba_pkg::OP_REQ);
    assign o_cfg_ready = 1'b1;

    // load path
    assign slot_ext  = {{IW{1'b0}}, i_slot};
    assign slot_ok   = (32'(i_slot) < NUM_BLOCKS);
    assign load_addr = slot_ext[IW-1:0];
    assign load_ext  = {{SIZE_BITS{1'b0}}, i_amount};
    assign load_size = load_ext[SIZE_BITS-1:0];
    assign load_wide = {{AW{1'b0}}, load_size};

    assign used_sat = (32'(r_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(r_count);

    // scan and shared compare unit
    assign issue     = (r_state == S_SCAN) && (r_idx < r_used);
    assign cur_size  = r_rd_vbit ? ram_rdata : '0;
    assign size_wide = {{AW{1'b0}}, cur_size};
    assign amt_wide  = {{SIZE_BITS{1'b0}}, r_amount};
    assign amt_trunc = amt_wide[SIZE_BITS-1:0];
    assign fits      = (size_wide >= amt_wide);
    assign rem       = cur_size - amt_trunc;
    assign better    = !r_found
                     || ((r_mode == fpba_pkg::MODE_BEST)  && (rem < r_best))
                     || ((r_mode == fpba_pkg::MODE_WORST) && (rem > r_best));
    assign take      = r_rd_vld && fits && better;

    assign pick_ext  = {{SW{1'b0}}, r_pick};
    assign best_wide = {{AW{1'b0}}, r_best};

    assign ram_we    = (load_acc && slot_ok) || ((r_state == S_WB) && r_found);
    assign ram_waddr = (r_state == S_WB) ? r_pick : load_addr;
    assign ram_wdata = (r_state == S_WB) ? r_best : load_size;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!issue && !r_rd_vld) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= fpba_pkg::MODE_RST;
            r_count  <= fpba_pkg::COUNT_RST;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_done   <= load_acc || (r_state == S_WB);
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (req_acc) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fpba_pkg::CFG_FIT_MODE:    r_mode  <= i_cfg_data[fpba_pkg::MODE_W-1:0];
                    fpba_pkg::CFG_BLOCK_COUNT: r_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_idx    <= '0;
            r_used   <= used_sat;
            r_amount <= i_amount;
        end else if (issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        r_rd_idx  <= r_idx[IW-1:0];
        r_rd_vbit <= issue ? r_vld[r_idx[IW-1:0]] : 1'b0;
        if (take) begin
            r_pick <= r_rd_idx;
            r_best <= rem;
        end
        if (load_acc) begin
            r_fit_found <= 1'b0;
            r_chosen    <= i_slot;
            r_left      <= slot_ok ? load_wide[AW-1:0] : '0;
        end else if (r_state == S_WB) begin
            r_fit_found <= r_found;
            r_chosen    <= r_found ? pick_ext[SW-1:0] : '0;
            r_left      <= r_found ? best_wide[AW-1:0] : '0;
        end
    end

    assign o_done        = r_done;
    assign o_fit_found   = r_fit_found;
    assign o_chosen_slot = r_chosen;
    assign o_left_over   = r_left;

    `FPBA_ASSERT_NXT(a_load_one_cycle, i_clk, i_rst_n, load_acc, o_done && !busy,
                     "load result missing")
    `FPBA_ASSERT_NXT(a_req_goes_busy, i_clk, i_rst_n, req_acc, busy,
                     "request did not start scan")
    `FPBA_ASSERT_IMP(a_result_on_exit, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n),
                     o_done, "request ended without result")
    `FPBA_ASSERT_IMP(a_pick_in_use, i_clk, i_rst_n, (r_state == S_WB) && r_found,
                     32'(r_pick) < 32'(r_used), "pick outside blocks in use")

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the fit-policy block allocator under every placement policy.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS    = 8;
    localparam int SETTLE_CYCLES = NUM_BLOCKS + 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 158;

    typedef struct packed {
        logic                          found;
        logic [fpba_pkg::SLOT_W-1:0]   slot;
        logic [fpba_pkg::AMOUNT_W-1:0] left;
    } t_alloc_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [fpba_pkg::OP_W-1:0]       i_op;
    logic [fpba_pkg::SLOT_W-1:0]     i_slot;
    logic [fpba_pkg::AMOUNT_W-1:0]   i_amount;
    logic                            o_done;
    logic                            o_fit_found;
    logic [fpba_pkg::SLOT_W-1:0]     o_chosen_slot;
    logic [fpba_pkg::AMOUNT_W-1:0]   o_left_over;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic [fpba_pkg::AMOUNT_W-1:0] shadow_sizes [NUM_BLOCKS];
    logic [fpba_pkg::MODE_W-1:0]   shadow_mode;
    logic [fpba_pkg::COUNT_W-1:0]  shadow_count;
    t_alloc_result                 pending_results [$];
    int                            mismatches;
    int                            cycle_count;

    fit_policy_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (fpba_pkg::AMOUNT_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_slot       (i_slot),
        .i_amount     (i_amount),
        .o_done       (o_done),
        .o_fit_found  (o_fit_found),
        .o_chosen_slot(o_chosen_slot),
        .o_left_over  (o_left_over),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** fit_policy_block_allocator: FAILED **");
            $finish;
        end
    end

    function automatic t_alloc_result predict_allocation(
            logic [fpba_pkg::OP_W-1:0] op,
            logic [fpba_pkg::SLOT_W-1:0] slot,
            logic [fpba_pkg::AMOUNT_W-1:0] amount);
        t_alloc_result                 res;
        int                            used;
        int                            pick;
        logic                          found;
        logic [fpba_pkg::AMOUNT_W-1:0] best;
        logic [fpba_pkg::AMOUNT_W-1:0] rem;
        if (op == fpba_pkg::OP_LOAD) begin
            shadow_sizes[slot] = amount;
            res.found = 1'b0;
            res.slot  = slot;
            res.left  = amount;
            return res;
        end
        used  = (shadow_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(shadow_count);
        found = 1'b0;
        pick  = 0;
        best  = '0;
        for (int i = 0; i < used; i++) begin
            if (shadow_sizes[i] >= amount) begin
                rem = shadow_sizes[i] - amount;
                if (!found) begin
                    found = 1'b1;
                    pick  = i;
                    best  = rem;
                    if (shadow_mode != fpba_pkg::MODE_BEST
                        && shadow_mode != fpba_pkg::MODE_WORST)
                        break;
                end else if (shadow_mode == fpba_pkg::MODE_BEST && rem < best) begin
                    pick = i;
                    best = rem;
                end else if (shadow_mode == fpba_pkg::MODE_WORST && rem > best) begin
                    pick = i;
                    best = rem;
                end
            end
        end
        if (!found) begin
            res = '0;
            return res;
        end
        shadow_sizes[pick] = best;
        res.found = 1'b1;
        res.slot  = fpba_pkg::SLOT_W'(pick);
        res.left  = best;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, o_fit_found, o_chosen_slot, o_left_over);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_fit_found !== want.found) begin
                    $display("%0t: fit_found expected %0d actual %0d",
                             $time, want.found, o_fit_found);
                    mismatches++;
                end
                if (o_chosen_slot !== want.slot) begin
                    $display("%0t: chosen_slot expected %0d actual %0d",
                             $time, want.slot, o_chosen_slot);
                    mismatches++;
                end
                if (o_left_over !== want.left) begin
                    $display("%0t: left_over expected %0d actual %0d",
                             $time, want.left, o_left_over);
                    mismatches++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(logic [fpba_pkg::OP_W-1:0] op,
                             logic [fpba_pkg::SLOT_W-1:0] slot,
                             logic [fpba_pkg::AMOUNT_W-1:0] amount);
        start    <= 1'b1;
        i_op     <= op;
        i_slot   <= slot;
        i_amount <= amount;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_results.push_back(predict_allocation(op, slot, amount));
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [fpba_pkg::CFG_IDX_W-1:0] index,
                                  logic [fpba_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        if (index == fpba_pkg::CFG_FIT_MODE)
            shadow_mode = data[fpba_pkg::MODE_W-1:0];
        else
            shadow_count = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reconfigure(logic [fpba_pkg::CFG_DATA_W-1:0] mode_data,
                               logic [fpba_pkg::CFG_DATA_W-1:0] count_data);
        drain_results();
        write_register(fpba_pkg::CFG_FIT_MODE, mode_data);
        write_register(fpba_pkg::CFG_BLOCK_COUNT, count_data);
    endtask

    task automatic test_empty_table();
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
        send_item(fpba_pkg::OP_REQ, 3'd7, 16'd1);
    endtask

    task automatic test_load_extremes();
        send_item(fpba_pkg::OP_LOAD, 3'd0, 16'd100);
        send_item(fpba_pkg::OP_LOAD, 3'd1, 16'd40);
        send_item(fpba_pkg::OP_LOAD, 3'd2, 16'hFFFF);
        send_item(fpba_pkg::OP_LOAD, 3'd3, 16'd0);
        send_item(fpba_pkg::OP_LOAD, 3'd4, 16'd40);
        send_item(fpba_pkg::OP_LOAD, 3'd5, 16'd200);
        send_item(fpba_pkg::OP_LOAD, 3'd6, 16'h5555);
        send_item(fpba_pkg::OP_LOAD, 3'd7, 16'hAAAA);
    endtask

    task automatic test_fit_policies();
        send_item(fpba_pkg::OP_REQ, 3'd5, 16'd30);
        reconfigure(fpba_pkg::CFG_DATA_W'(fpba_pkg::MODE_BEST), 4'd8);
        send_item(fpba_pkg::OP_REQ, 3'd2, 16'd30);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd10);
        reconfigure(fpba_pkg::CFG_DATA_W'(fpba_pkg::MODE_WORST), 4'd8);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd30);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'hFFFF);
        // mode three falls back to first fit; upper data bits are dropped
        reconfigure(4'hF, 4'd8);
        send_item(fpba_pkg::OP_REQ, 3'd1, 16'd50);
    endtask

    task automatic test_block_count_limits();
        reconfigure(4'hC, 4'd0);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
        reconfigure(fpba_pkg::CFG_DATA_W'(fpba_pkg::MODE_BEST), 4'd1);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
        send_item(fpba_pkg::OP_LOAD, 3'd7, 16'd5000);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd4000);
        reconfigure(fpba_pkg::CFG_DATA_W'(fpba_pkg::MODE_WORST), 4'hF);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd4000);
        send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
    endtask

    task automatic test_random_traffic(int items, int idle_pct);
        logic [fpba_pkg::OP_W-1:0]     op;
        logic [fpba_pkg::SLOT_W-1:0]   slot;
        logic [fpba_pkg::AMOUNT_W-1:0] amount;
        int                            roll;
        for (int n = 0; n < items; n++) begin
            // hold off until the block is empty once per phase
            if (n == items / 2)
                drain_results();
            slot = fpba_pkg::SLOT_W'($urandom_range(NUM_BLOCKS - 1));
            roll = $urandom_range(99);
            if ($urandom_range(99) < 35) begin
                op = fpba_pkg::OP_LOAD;
                if (roll < 10)
                    amount = '0;
                else if (roll < 20)
                    amount = '1;
                else if (roll < 40)
                    amount = shadow_sizes[$urandom_range(NUM_BLOCKS - 1)];
                else
                    amount = fpba_pkg::AMOUNT_W'($urandom);
            end else begin
                op = fpba_pkg::OP_REQ;
                if (roll < 10)
                    amount = '0;
                else if (roll < 25)
                    amount = shadow_sizes[$urandom_range(NUM_BLOCKS - 1)];
                else if (roll < 35)
                    amount = fpba_pkg::AMOUNT_W'($urandom);
                else
                    amount = fpba_pkg::AMOUNT_W'($urandom_range(16'h3FFF));
            end
            send_item(op, slot, amount);
            idle_gap(idle_pct);
        end
    endtask

    initial begin
        int idle_pct;
        logic [fpba_pkg::CFG_DATA_W-1:0] count_data;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = fpba_pkg::OP_LOAD;
        i_slot      = '0;
        i_amount    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = fpba_pkg::CFG_FIT_MODE;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycle_count = 0;
        foreach (shadow_sizes[i])
            shadow_sizes[i] = '0;
        shadow_mode  = fpba_pkg::MODE_RST;
        shadow_count = fpba_pkg::COUNT_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_load_extremes();
        test_fit_policies();
        test_block_count_limits();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 79;
                default: idle_pct = 20;
            endcase
            case (p)
                0: count_data = 4'd8;
                1: count_data = 4'd1;
                2: count_data = 4'hF;
                3: count_data = 4'd0;
                default: count_data = fpba_pkg::CFG_DATA_W'($urandom_range(1, 15));
            endcase
            reconfigure(fpba_pkg::CFG_DATA_W'(p), count_data);
            test_random_traffic(PHASE_ITEMS, idle_pct);
        end

        drain_results();
        if (mismatches == 0)
            $display("** fit_policy_block_allocator: PASSED **");
        else
            $display("** fit_policy_block_allocator: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire
